// ===== rtl/sedd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sedd_pkg;

  // Frame size limits and the storage widths that follow from them.
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int EW         = $clog2(MAX_WIDTH + 1);
  localparam int LINE_W     = $clog2(MAX_HEIGHT + 1);

  // Fixed widths of the configuration registers and of the result fields.
  localparam int DIM_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int POS_OUT_W = 11;
  localparam int LEVEL_W   = 3;

  // Arithmetic widths: stored error, gray sum before clamping, weighted products.
  localparam int ERR_W  = 10;
  localparam int GSUM_W = 11;
  localparam int PROD_W = 12;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_MODE   = 2'd2
  } cfg_reg_t;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(1200);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(825);

  // Quantizer modes.
  localparam logic MODE_MONO = 1'b0;

  // Smallest gray value that reaches each of the levels 1..7 under
  // level = (7 * g + 127) / 255.
  localparam logic [7:0] LEVEL_THRESH [0:6] = '{
    8'd19, 8'd55, 8'd92, 8'd128, 8'd164, 8'd201, 8'd237
  };

  // Reconstructed gray of each level: (level * 255 + 3) / 7.
  localparam logic [7:0] LEVEL_GRAY [0:7] = '{
    8'd0, 8'd36, 8'd73, 8'd109, 8'd146, 8'd182, 8'd219, 8'd255
  };

  // Scan position of one pixel, as handed from the scan counters to the datapath.
  typedef struct packed {
    logic [COL_W-1:0]  x;
    logic [LINE_W-1:0] y;
    logic              odd_line;
    logic              first_line;
    logic              first_col;
    logic              frame_end;
  } pos_t;

  // Eight-level quantizer: count the thresholds that the gray value reaches.
  function automatic logic [LEVEL_W-1:0] gray_level(input logic [7:0] g);
    logic [LEVEL_W-1:0] cnt;
    cnt = '0;
    for (int k = 0; k < 7; k++) begin
      if (g >= LEVEL_THRESH[k]) begin
        cnt = cnt + LEVEL_W'(1);
      end
    end
    return cnt;
  endfunction

  // Signed divide by 16 with truncation toward zero.
  function automatic logic signed [ERR_W-1:0] div16_trunc(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] adj;
    adj = p + (p[PROD_W-1] ? PROD_W'(15) : PROD_W'(0));
    return ERR_W'(adj >>> 4);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/serpentine_error_diffusion_dither_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Serpentine Floyd-Steinberg dither: one 8-bit gray pixel in, one display level
// out, with its column, line and an end-of-frame flag. Pixels arrive in
// serpentine order (even lines left to right, odd lines right to left) and the
// block takes one pixel per clock cycle while the output is not stalled. A
// pixel passes an input register that also latches the previous line's error
// from a single row buffer, then the quantizer and diffusion logic into the
// output register. The error toward the next pixel and the partial sums for
// the line below sit in registers, so the row buffer sees one read and at most
// one write per pixel. It needs no clearing after reset: the first line of
// each frame ignores it. Writing any register (index 0 width, 1 height,
// 2 mode) restarts the frame and is to be done only while the block is idle;
// the block itself does not enforce it. The configuration port is always ready.
module serpentine_error_diffusion_dither_core
  import sedd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_pixel_value,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [LEVEL_W-1:0]        out_level,
  output logic [POS_OUT_W-1:0]      out_column,
  output logic [POS_OUT_W-1:0]      out_line,
  output logic                      out_frame_end,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data
);

  logic [DIM_W-1:0]  width_r;
  logic [DIM_W-1:0]  height_r;
  logic              mode_r;
  logic              cfg_we;
  logic              restart;
  logic [EW-1:0]     w_eff;
  logic [LINE_W-1:0] h_eff;

  pos_t              pos;
  logic              accept;
  logic              s1_move;
  logic              s1_vld_r;
  logic              s1_vld_nxt;
  logic [7:0]        s1_pix_r;
  pos_t              s1_pos_r;
  logic              out_vld_r;
  logic              out_vld_nxt;

  logic [ERR_W-1:0]        mem_q;
  logic                    mem_we;
  logic [COL_W-1:0]        mem_waddr;
  logic [ERR_W-1:0]        mem_wdata;
  logic signed [ERR_W-1:0] fwd_r;
  logic signed [ERR_W-1:0] nx_a_r;
  logic signed [ERR_W-1:0] nx_b_r;
  logic signed [ERR_W-1:0] base_err;
  logic signed [ERR_W-1:0] fwd_err;
  logic [LEVEL_W-1:0]      level;
  logic signed [ERR_W-1:0] e7;
  logic signed [ERR_W-1:0] e5;
  logic signed [ERR_W-1:0] e3;
  logic signed [ERR_W-1:0] e1;

  // Configuration registers; a write to a known index restarts the frame.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_comb begin
    case (cfg_index)
      REG_WIDTH, REG_HEIGHT, REG_MODE: restart = cfg_we;
      default:                         restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      mode_r   <= MODE_MONO;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        REG_MODE:   mode_r   <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  // Frame size clamped to 1..maximum.
  always_comb begin
    if (width_r == '0) begin
      w_eff = EW'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(width_r);
    end
    if (height_r == '0) begin
      h_eff = LINE_W'(1);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      h_eff = LINE_W'(MAX_HEIGHT);
    end else begin
      h_eff = LINE_W'(height_r);
    end
  end

  // Two-stage flow control: input register, then output register.
  assign s1_move     = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall    = s1_vld_r && !s1_move;
  assign accept      = in_valid && !in_stall;
  assign s1_vld_nxt  = accept || (s1_vld_r && !s1_move);
  assign out_vld_nxt = s1_move || (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  sedd_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (accept),
    .restart (restart),
    .w_eff   (w_eff),
    .h_eff   (h_eff),
    .pos     (pos)
  );

  // Input register: pixel and its scan position.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r <= in_pixel_value;
      s1_pos_r <= pos;
    end
  end

  // Row buffer: previous line's error is read as the pixel is taken; the
  // completed entry behind the current pixel is written as it leaves.
  sedd_line_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (accept),
    .rd_addr (pos.x),
    .rd_data (mem_q)
  );

  // Error arriving at this pixel: from the line above and from its neighbor.
  // The first pixel of a line takes the line above from the partial-sum
  // register, since that entry was finished by the last pixel of that line.
  always_comb begin
    if (s1_pos_r.first_line) begin
      base_err = '0;
    end else if (s1_pos_r.first_col) begin
      base_err = nx_a_r;
    end else begin
      base_err = $signed(mem_q);
    end
    fwd_err = s1_pos_r.first_col ? '0 : fwd_r;
  end

  sedd_quant u_quant (
    .mode     (mode_r),
    .pixel    (s1_pix_r),
    .base_err (base_err),
    .fwd_err  (fwd_err),
    .level    (level),
    .e7       (e7),
    .e5       (e5),
    .e3       (e3),
    .e1       (e1)
  );

  // Finish the line-below entry of the previous pixel in this line.
  always_comb begin
    mem_we    = s1_move && !s1_pos_r.first_col;
    mem_wdata = nx_a_r + e3;
    if (s1_pos_r.odd_line) begin
      mem_waddr = s1_pos_r.x + COL_W'(1);
    end else begin
      mem_waddr = s1_pos_r.x - COL_W'(1);
    end
  end

  // Running diffusion state, advanced as each pixel leaves the input register.
  always_ff @(posedge clk) begin
    if (s1_move) begin
      fwd_r  <= e7;
      nx_a_r <= s1_pos_r.first_col ? e5 : nx_b_r + e5;
      nx_b_r <= e1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_level     <= level;
      out_column    <= POS_OUT_W'(s1_pos_r.x);
      out_line      <= POS_OUT_W'(s1_pos_r.y);
      out_frame_end <= s1_pos_r.frame_end;
    end
  end

  assign out_valid = out_vld_r;

endmodule

`default_nettype wire

// ===== rtl/sedd_line_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sedd_line_mem
  import sedd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [COL_W-1:0] wr_addr,
  input  wire logic [ERR_W-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [COL_W-1:0] rd_addr,
  output logic      [ERR_W-1:0] rd_data
);

  // One row of diffused error; written behind the scan and read ahead of it.
  logic [ERR_W-1:0] mem [0:MAX_WIDTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; the data holds while no new pixel is taken.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sedd_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sedd_scan
  import sedd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              advance,
  input  wire logic              restart,
  input  wire logic [EW-1:0]     w_eff,
  input  wire logic [LINE_W-1:0] h_eff,
  output pos_t                   pos
);

  logic [COL_W-1:0]  col_r;
  logic [COL_W-1:0]  col_nxt;
  logic [LINE_W-1:0] line_r;
  logic [LINE_W-1:0] line_nxt;
  logic              last_col;
  logic              last_line;

  // Position of the pixel that the next request carries.
  always_comb begin
    last_col  = (EW'(col_r) + EW'(1)) >= w_eff;
    last_line = (line_r + LINE_W'(1)) >= h_eff;

    pos.y          = line_r;
    pos.odd_line   = line_r[0];
    pos.first_line = (line_r == '0);
    pos.first_col  = (col_r == '0);
    pos.frame_end  = last_col && last_line;
    if (line_r[0]) begin
      pos.x = COL_W'(w_eff - EW'(1) - EW'(col_r));
    end else begin
      pos.x = col_r;
    end
  end

  // Column and line counters; a register write starts a new frame.
  always_comb begin
    col_nxt  = col_r;
    line_nxt = line_r;
    if (restart) begin
      col_nxt  = '0;
      line_nxt = '0;
    end else if (advance) begin
      if (last_col) begin
        col_nxt  = '0;
        line_nxt = last_line ? '0 : line_r + LINE_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      line_r <= '0;
    end else begin
      col_r  <= col_nxt;
      line_r <= line_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sedd_quant.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sedd_quant
  import sedd_pkg::*;
(
  input  wire logic                    mode,
  input  wire logic [7:0]              pixel,
  input  wire logic signed [ERR_W-1:0] base_err,
  input  wire logic signed [ERR_W-1:0] fwd_err,
  output logic [LEVEL_W-1:0]           level,
  output logic signed [ERR_W-1:0]      e7,
  output logic signed [ERR_W-1:0]      e5,
  output logic signed [ERR_W-1:0]      e3,
  output logic signed [ERR_W-1:0]      e1
);

  logic signed [GSUM_W-1:0] gsum;
  logic [7:0]               gray;
  logic [LEVEL_W-1:0]       glevel;
  logic [7:0]               qgray;
  logic signed [ERR_W-1:0]  err;
  logic signed [PROD_W-1:0] err_x;

  // Add the accumulated error and clamp to the pixel range.
  always_comb begin
    gsum = $signed({3'b000, pixel}) + GSUM_W'(base_err) + GSUM_W'(fwd_err);
    if (gsum[GSUM_W-1]) begin
      gray = 8'd0;
    end else if (gsum > GSUM_W'(255)) begin
      gray = 8'd255;
    end else begin
      gray = gsum[7:0];
    end
  end

  // Quantize: one bit with inverted sense (1 is ink), or eight gray levels.
  always_comb begin
    glevel = gray_level(gray);
    if (mode == MODE_MONO) begin
      level = {2'b00, ~gray[7]};
      qgray = gray[7] ? 8'd255 : 8'd0;
    end else begin
      level = glevel;
      qgray = LEVEL_GRAY[glevel];
    end
  end

  // Quantization error split into the four Floyd-Steinberg shares.
  always_comb begin
    err   = $signed({2'b00, gray}) - $signed({2'b00, qgray});
    err_x = PROD_W'(err);
    e7    = div16_trunc(err_x * PROD_W'(7));
    e5    = div16_trunc(err_x * PROD_W'(5));
    e3    = div16_trunc(err_x * PROD_W'(3));
    e1    = div16_trunc(err_x);
  end

endmodule

`default_nettype wire

// ===== rtl/sedd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sedd_checker
  import sedd_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [LEVEL_W-1:0]   out_level,
  input wire logic [POS_OUT_W-1:0] out_column,
  input wire logic [POS_OUT_W-1:0] out_line,
  input wire logic                 out_frame_end,
  input wire logic                 cfg_valid,
  input wire logic                 cfg_ready,
  input wire logic [CFG_IDX_W-1:0] cfg_index,
  input wire logic [DIM_W-1:0]     cfg_data
);

  logic                 out_take;
  logic                 restart;
  logic                 start_r;
  logic [POS_OUT_W-1:0] prev_col_r;
  logic [POS_OUT_W-1:0] prev_line_r;

  assign out_take = out_valid && !out_stall;
  assign restart  = cfg_valid && cfg_ready &&
                    (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
                     cfg_index == REG_MODE);

  // Track where the next result must fall: a frame start, or next to the last one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 1'b1;
    end else if (restart) begin
      start_r <= 1'b1;
    end else if (out_take) begin
      start_r <= out_frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      prev_col_r  <= out_column;
      prev_line_r <= out_line;
    end
  end

  // No result is shown straight after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds its fields.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_level) &&
      $stable(out_column) && $stable(out_line) && $stable(out_frame_end))
    else $error("stalled result changed");

  // The first result of a frame is the top-left pixel.
  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && start_r |-> out_line == '0 && out_column == '0)
    else $error("frame did not start at the origin");

  // Within a line the scan moves one column per result.
  a_serpentine_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !start_r && out_line == prev_line_r |->
      out_column == prev_col_r + POS_OUT_W'(1) ||
      prev_col_r == out_column + POS_OUT_W'(1))
    else $error("column did not step by one within a line");

endmodule

bind serpentine_error_diffusion_dither_core sedd_checker u_sedd_checker (.*);

`default_nettype wire
